### hw/rtl/pis_pkg.sv
// types and constants shared by the priority interrupt selector modules
`default_nettype none

package pis_pkg;

   // fixed widths of the request and response fields
   localparam int ACTION_W = 3;
   localparam int SRC_W    = 7;
   localparam int LEVEL_W  = 8;
   localparam int STATUS_W = 2;

   // request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_SETPRIO  = 3'd0,
      ACT_ENABLE   = 3'd1,
      ACT_DISABLE  = 3'd2,
      ACT_RAISE    = 3'd3,
      ACT_DISPATCH = 3'd4
   } action_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADSRC = 2'd1,
      ST_LOCKED = 2'd2
   } status_type;

   // operation broadcast to every list cell
   typedef enum logic [2:0] {
      CELL_NONE     = 3'd0,
      CELL_INSERT   = 3'd1,
      CELL_REMOVE   = 3'd2,
      CELL_RAISE    = 3'd3,
      CELL_DISPATCH = 3'd4
   } cell_op_type;

   // command seen by all cells in the same cycle
   typedef struct packed {
      cell_op_type      op;
      logic [SRC_W-1:0] src;
      logic             pend;
   } cell_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/pis_cell.sv
// one slot of the sorted list of enabled sources
`default_nettype none

module pis_cell #(
   parameter int LevelBits = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pis_pkg::cell_cmd_type     cmd,
   input  wire logic [LevelBits-1:0]      cmd_level,
   // neighbor toward the head of the list
   input  wire logic                      left_occ,
   input  wire logic [pis_pkg::SRC_W-1:0] left_src,
   input  wire logic [LevelBits-1:0]      left_prio,
   input  wire logic                      left_pend,
   // neighbor toward the tail of the list
   input  wire logic                      right_occ,
   input  wire logic [pis_pkg::SRC_W-1:0] right_src,
   input  wire logic [LevelBits-1:0]      right_prio,
   input  wire logic                      right_pend,
   // own contents
   output logic                           occ,
   output logic [pis_pkg::SRC_W-1:0]      src,
   output logic [LevelBits-1:0]           prio,
   output logic                           pend,
   // flags handed along the row
   input  wire logic                      ins_i,
   output logic                           ins_o,
   input  wire logic                      del_i,
   output logic                           del_o,
   input  wire logic                      hit_i,
   output logic                           hit_o,
   output logic                           first_o
);

   logic                      occ_ff,  occ_in;
   logic [pis_pkg::SRC_W-1:0] src_ff,  src_in;
   logic [LevelBits-1:0]      prio_ff, prio_in;
   logic                      pend_ff, pend_in;
   logic                      match;
   logic                      avail;

   // slot holds the addressed source
   assign match = occ_ff & (src_ff == cmd.src);

   // new entry goes at or before this slot when the slot is empty or the new level is strictly higher
   assign ins_o = !occ_ff | (cmd_level > prio_ff);

   // removal shifts this slot and every slot after the match
   assign del_o = del_i | match;

   // first pending entry in list order
   assign avail   = occ_ff & pend_ff;
   assign hit_o   = hit_i | avail;
   assign first_o = avail & !hit_i;

   // next contents
   always_comb begin
      occ_in  = occ_ff;
      src_in  = src_ff;
      prio_in = prio_ff;
      pend_in = pend_ff;
      case (cmd.op)
         pis_pkg::CELL_INSERT: begin
            if (ins_o && !ins_i) begin
               occ_in  = 1'b1;
               src_in  = cmd.src;
               prio_in = cmd_level;
               pend_in = cmd.pend;
            end else if (ins_o) begin
               occ_in  = left_occ;
               src_in  = left_src;
               prio_in = left_prio;
               pend_in = left_pend;
            end
         end
         pis_pkg::CELL_REMOVE: begin
            if (del_o) begin
               occ_in  = right_occ;
               src_in  = right_src;
               prio_in = right_prio;
               pend_in = right_pend;
            end
         end
         pis_pkg::CELL_RAISE: begin
            if (match) begin
               pend_in = 1'b1;
            end
         end
         pis_pkg::CELL_DISPATCH: begin
            if (first_o) begin
               pend_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         occ_ff  <= occ_in;
         pend_ff <= pend_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      prio_ff <= prio_in;
   end

   assign occ  = occ_ff;
   assign src  = src_ff;
   assign prio = prio_ff;
   assign pend = pend_ff;

endmodule

`default_nettype wire

### hw/rtl/priority_interrupt_selector_top.sv
// top level of the priority interrupt selector
//
// Priority interrupt selector. Each request (set priority, enable, disable,
// raise pending, dispatch) is captured along with its source's priority from
// the priority memory; then the list is updated and the response register
// loaded, which waits while a loaded response is stalled. A new request is
// taken the cycle after a response is loaded, also while that response still
// waits. Enabled sources live in a row of NUM_SOURCES list cells sorted by
// falling priority; an enable inserts after all equal levels, a disable
// closes the gap, and both shift all later entries at once. Dispatch returns
// the first pending entry in list order. The longest path is the pending hit
// flag rippling through the cell row. No clearing pass follows reset.
`default_nettype none

module priority_interrupt_selector_top #(
   parameter int NUM_SOURCES = 96,
   parameter int LEVEL_BITS  = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [pis_pkg::ACTION_W-1:0] req_action,
   input  wire logic [pis_pkg::SRC_W-1:0]    req_source,
   input  wire logic [pis_pkg::LEVEL_W-1:0]  req_level,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [pis_pkg::STATUS_W-1:0]      rsp_status,
   output logic                              rsp_found,
   output logic [pis_pkg::SRC_W-1:0]         rsp_winner,
   output logic                              rsp_was_enabled
);

   localparam int SIDX = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   // captured request
   logic                          busy_ff;
   pis_pkg::action_type           act_ff;
   logic [pis_pkg::SRC_W-1:0]     src_ff;
   logic [LEVEL_BITS-1:0]         lvl_ff;
   logic                          srcok_ff;
   logic [LEVEL_BITS-1:0]         prio_rd_ff;
   logic                          prio_set_ff;

   // per-source state
   logic [LEVEL_BITS-1:0]         prio_mem [NUM_SOURCES];
   logic [NUM_SOURCES-1:0]        prio_vld_ff;
   logic [NUM_SOURCES-1:0]        enabled_ff;
   logic [NUM_SOURCES-1:0]        pending_ff;

   // response register
   logic                          rsp_valid_ff;
   pis_pkg::status_type           status_ff;
   logic                          found_ff;
   logic [pis_pkg::SRC_W-1:0]     winner_ff;
   logic                          was_ff;

   logic                          accept;
   logic                          exec;
   logic [SIDX-1:0]               req_idx;
   logic [SIDX-1:0]               idx;
   logic                          src_en;
   logic [LEVEL_BITS-1:0]         cur_prio;
   pis_pkg::cell_op_type          op;
   pis_pkg::status_type           status;
   logic                          was;
   logic                          prio_wr;
   pis_pkg::cell_cmd_type         cmd;
   logic                          found;
   logic [pis_pkg::SRC_W-1:0]     winner;

   // cell row wires
   logic                          occ_w   [NUM_SOURCES];
   logic [pis_pkg::SRC_W-1:0]     src_w   [NUM_SOURCES];
   logic [LEVEL_BITS-1:0]         prio_w  [NUM_SOURCES];
   logic                          pend_w  [NUM_SOURCES];
   logic                          first_w [NUM_SOURCES];
   logic [NUM_SOURCES:0]          ins_c;
   logic [NUM_SOURCES:0]          del_c;
   logic [NUM_SOURCES:0]          hit_c;

   // handshake
   assign accept    = req_valid & !busy_ff;
   assign exec      = busy_ff & (!rsp_valid_ff | !rsp_stall);
   assign req_stall = busy_ff | reset;
   assign req_idx   = req_source[SIDX-1:0];
   assign idx       = src_ff[SIDX-1:0];

   // request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (exec) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff      <= pis_pkg::action_type'(req_action);
         src_ff      <= req_source;
         lvl_ff      <= req_level[LEVEL_BITS-1:0];
         srcok_ff    <= 32'(req_source) < NUM_SOURCES;
         prio_rd_ff  <= prio_mem[req_idx];
         prio_set_ff <= prio_vld_ff[req_idx];
      end
   end

   // priority memory, never-written entries read as zero
   always_ff @(posedge clock) begin
      if (exec && prio_wr) begin
         prio_mem[idx] <= lvl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_vld_ff <= '0;
      end else if (exec && prio_wr) begin
         prio_vld_ff[idx] <= 1'b1;
      end
   end

   assign cur_prio = prio_set_ff ? prio_rd_ff : '0;
   assign src_en   = enabled_ff[idx];

   // action decode
   always_comb begin
      op      = pis_pkg::CELL_NONE;
      status  = pis_pkg::ST_OK;
      was     = 1'b0;
      prio_wr = 1'b0;
      case (act_ff)
         pis_pkg::ACT_SETPRIO: begin
            if (!srcok_ff) begin
               status = pis_pkg::ST_BADSRC;
            end else if (src_en) begin
               status = pis_pkg::ST_LOCKED;
            end else begin
               prio_wr = 1'b1;
            end
         end
         pis_pkg::ACT_ENABLE: begin
            if (!srcok_ff) begin
               status = pis_pkg::ST_BADSRC;
            end else if (!src_en) begin
               op = pis_pkg::CELL_INSERT;
            end
         end
         pis_pkg::ACT_DISABLE: begin
            if (!srcok_ff) begin
               status = pis_pkg::ST_BADSRC;
            end else if (src_en) begin
               op  = pis_pkg::CELL_REMOVE;
               was = 1'b1;
            end
         end
         pis_pkg::ACT_RAISE: begin
            if (!srcok_ff) begin
               status = pis_pkg::ST_BADSRC;
            end else begin
               op = pis_pkg::CELL_RAISE;
            end
         end
         pis_pkg::ACT_DISPATCH: begin
            op = pis_pkg::CELL_DISPATCH;
         end
         default: begin
         end
      endcase
   end

   assign cmd.op   = exec ? op : pis_pkg::CELL_NONE;
   assign cmd.src  = src_ff;
   assign cmd.pend = pending_ff[idx];

   // cell row
   assign ins_c[0] = 1'b0;
   assign del_c[0] = 1'b0;
   assign hit_c[0] = 1'b0;

   for (genvar k = 0; k < NUM_SOURCES; k++) begin : g_cell
      logic                      l_occ;
      logic [pis_pkg::SRC_W-1:0] l_src;
      logic [LEVEL_BITS-1:0]     l_prio;
      logic                      l_pend;
      logic                      r_occ;
      logic [pis_pkg::SRC_W-1:0] r_src;
      logic [LEVEL_BITS-1:0]     r_prio;
      logic                      r_pend;

      if (k == 0) begin : g_head
         assign l_occ  = 1'b0;
         assign l_src  = '0;
         assign l_prio = '0;
         assign l_pend = 1'b0;
      end else begin : g_mid_l
         assign l_occ  = occ_w[k-1];
         assign l_src  = src_w[k-1];
         assign l_prio = prio_w[k-1];
         assign l_pend = pend_w[k-1];
      end

      if (k == NUM_SOURCES - 1) begin : g_tail
         assign r_occ  = 1'b0;
         assign r_src  = '0;
         assign r_prio = '0;
         assign r_pend = 1'b0;
      end else begin : g_mid_r
         assign r_occ  = occ_w[k+1];
         assign r_src  = src_w[k+1];
         assign r_prio = prio_w[k+1];
         assign r_pend = pend_w[k+1];
      end

      pis_cell #(
         .LevelBits (LEVEL_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cmd_level  (cur_prio),
         .left_occ   (l_occ),
         .left_src   (l_src),
         .left_prio  (l_prio),
         .left_pend  (l_pend),
         .right_occ  (r_occ),
         .right_src  (r_src),
         .right_prio (r_prio),
         .right_pend (r_pend),
         .occ        (occ_w[k]),
         .src        (src_w[k]),
         .prio       (prio_w[k]),
         .pend       (pend_w[k]),
         .ins_i      (ins_c[k]),
         .ins_o      (ins_c[k+1]),
         .del_i      (del_c[k]),
         .del_o      (del_c[k+1]),
         .hit_i      (hit_c[k]),
         .hit_o      (hit_c[k+1]),
         .first_o    (first_w[k])
      );
   end

   // dispatch result: at most one cell flags itself first
   assign found = hit_c[NUM_SOURCES];

   always_comb begin
      winner = '0;
      for (int k = 0; k < NUM_SOURCES; k++) begin
         if (first_w[k]) begin
            winner = winner | src_w[k];
         end
      end
   end

   // enabled and pending maps
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= '0;
         pending_ff <= '0;
      end else if (exec) begin
         case (op)
            pis_pkg::CELL_INSERT: begin
               enabled_ff[idx] <= 1'b1;
            end
            pis_pkg::CELL_REMOVE: begin
               enabled_ff[idx] <= 1'b0;
            end
            pis_pkg::CELL_RAISE: begin
               pending_ff[idx] <= 1'b1;
            end
            pis_pkg::CELL_DISPATCH: begin
               if (found) begin
                  pending_ff[winner[SIDX-1:0]] <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff <= status;
         found_ff  <= (op == pis_pkg::CELL_DISPATCH) & found;
         winner_ff <= (op == pis_pkg::CELL_DISPATCH) ? winner : '0;
         was_ff    <= was;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_winner      = winner_ff;
   assign rsp_was_enabled = was_ff;

endmodule

`default_nettype wire

### bench/pis_checker.sv
// checker for the priority interrupt selector: predicts each response and compares it
`default_nettype none

module pis_checker #(
   parameter int NUM_SRC = 96
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [pis_pkg::ACTION_W-1:0] req_action,
   input  wire logic [pis_pkg::SRC_W-1:0]    req_source,
   input  wire logic [pis_pkg::LEVEL_W-1:0]  req_level,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [pis_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic                         rsp_found,
   input  wire logic [pis_pkg::SRC_W-1:0]    rsp_winner,
   input  wire logic                         rsp_was_enabled,
   output int                                errors,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [pis_pkg::STATUS_W-1:0] status;
      logic                         found;
      logic [pis_pkg::SRC_W-1:0]    winner;
      logic                         was_enabled;
   } answer_type;

   // shadow of the controller state
   logic [pis_pkg::LEVEL_W-1:0] level_of [NUM_SRC];
   logic [pis_pkg::SRC_W-1:0]   service_order [NUM_SRC];
   int                          listed;
   bit                          is_enabled [NUM_SRC];
   bit                          is_pending [NUM_SRC];

   answer_type                  due_answers [$];
   int                          fail_count = 0;

   // apply one request to the shadow state and work out its response
   task automatic serve_request(input logic [pis_pkg::ACTION_W-1:0] act,
                                input logic [pis_pkg::SRC_W-1:0] src,
                                input logic [pis_pkg::LEVEL_W-1:0] lvl,
                                output answer_type ans);
      int pos;
      int k;
      ans.status = pis_pkg::ST_OK;
      ans.found = 1'b0;
      ans.winner = '0;
      ans.was_enabled = 1'b0;
      if (act <= pis_pkg::ACT_RAISE && src >= NUM_SRC) begin
         ans.status = pis_pkg::ST_BADSRC;
      end else begin
         case (act)
            pis_pkg::ACT_SETPRIO: begin
               if (is_enabled[src])
                  ans.status = pis_pkg::ST_LOCKED;
               else
                  level_of[src] = lvl;
            end
            pis_pkg::ACT_ENABLE: begin
               if (!is_enabled[src]) begin
                  // goes behind every entry of equal or higher level
                  pos = 0;
                  while (pos < listed && level_of[src] <= level_of[service_order[pos]])
                     pos++;
                  for (k = listed; k > pos; k--)
                     service_order[k] = service_order[k-1];
                  service_order[pos] = src;
                  listed++;
                  is_enabled[src] = 1'b1;
               end
            end
            pis_pkg::ACT_DISABLE: begin
               if (is_enabled[src]) begin
                  ans.was_enabled = 1'b1;
                  pos = 0;
                  while (service_order[pos] != src)
                     pos++;
                  for (k = pos; k + 1 < listed; k++)
                     service_order[k] = service_order[k+1];
                  listed--;
                  service_order[listed] = '0;
                  is_enabled[src] = 1'b0;
               end
            end
            pis_pkg::ACT_RAISE: begin
               is_pending[src] = 1'b1;
            end
            pis_pkg::ACT_DISPATCH: begin
               // first pending entry in list order wins
               for (k = 0; k < listed; k++) begin
                  if (is_pending[service_order[k]]) begin
                     is_pending[service_order[k]] = 1'b0;
                     ans.found = 1'b1;
                     ans.winner = service_order[k];
                     break;
                  end
               end
            end
            default: ;
         endcase
      end
   endtask

   function automatic int field_mismatch(string name, int want, int got);
      if (want == got)
         return 0;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   // watch both channels at every edge
   always @(posedge clock) begin : watch
      answer_type want;
      answer_type fresh;
      if (reset) begin
         for (int i = 0; i < NUM_SRC; i++) begin
            level_of[i] = '0;
            service_order[i] = '0;
            is_enabled[i] = 1'b0;
            is_pending[i] = 1'b0;
         end
         listed = 0;
         due_answers.delete();
      end else begin
         // response side
         if (rsp_valid && !rsp_stall) begin
            if (due_answers.size() == 0) begin
               $display("%0t: response with none expected, status %0d found %0d winner %0d",
                        $time, rsp_status, rsp_found, rsp_winner);
               fail_count++;
            end else begin
               want = due_answers.pop_front();
               fail_count += field_mismatch("status", int'(want.status), int'(rsp_status));
               fail_count += field_mismatch("found", int'(want.found), int'(rsp_found));
               fail_count += field_mismatch("winner", int'(want.winner), int'(rsp_winner));
               fail_count += field_mismatch("was_enabled", int'(want.was_enabled),
                                            int'(rsp_was_enabled));
            end
         end
         // request side
         if (req_valid && !req_stall) begin
            serve_request(req_action, req_source, req_level, fresh);
            due_answers.push_back(fresh);
         end
      end
      errors <= fail_count;
      outstanding <= due_answers.size();
   end

endmodule

`default_nettype wire

### bench/tb.sv
// stimulus and verdict for the priority interrupt selector
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [pis_pkg::ACTION_W-1:0] act_code_type;
   typedef logic [pis_pkg::SRC_W-1:0]    src_num_type;
   typedef logic [pis_pkg::LEVEL_W-1:0]  level_type;

   // action codes the block does not use
   localparam act_code_type ACT_RSVD5 = 3'd5;
   localparam act_code_type ACT_RSVD7 = 3'd7;

   localparam src_num_type SRC_LAST      = 7'd95;
   localparam src_num_type SRC_FIRST_BAD = 7'd96;
   localparam src_num_type SRC_TOP       = 7'd127;

   localparam int RANDOM_ITEMS = 1550;
   localparam int QUIET_TAIL   = 150;
   localparam int HOLD_CYCLES  = 300;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   act_code_type                 req_action = '0;
   src_num_type                  req_source = '0;
   level_type                    req_level = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [pis_pkg::STATUS_W-1:0] rsp_status;
   logic                         rsp_found;
   src_num_type                  rsp_winner;
   logic                         rsp_was_enabled;

   int                  errors;
   int                  outstanding;
   bit                  quiet = 1'b0;
   bit                  hold_wanted = 1'b0;

   priority_interrupt_selector_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_source      (req_source),
      .req_level       (req_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_winner      (rsp_winner),
      .rsp_was_enabled (rsp_was_enabled)
   );

   pis_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_source      (req_source),
      .req_level       (req_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_winner      (rsp_winner),
      .rsp_was_enabled (rsp_was_enabled),
      .errors          (errors),
      .outstanding     (outstanding)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // offer one request, with an occasional idle burst ahead of it
   task automatic offer(input act_code_type act, input src_num_type src,
                        input level_type lvl);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_source <= src;
      req_level <= lvl;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // response side: random stall bursts, one long hold-off
   initial begin
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // request side and verdict
   initial begin
      int roll;
      int spin;
      act_code_type act;
      src_num_type  src;
      level_type    lvl;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // dispatch with nothing enabled
      offer(pis_pkg::ACT_DISPATCH, '0, '0);
      // bad sources on every action that takes one
      offer(pis_pkg::ACT_SETPRIO, SRC_FIRST_BAD, 8'hff);
      offer(pis_pkg::ACT_ENABLE, SRC_TOP, '0);
      offer(pis_pkg::ACT_DISABLE, SRC_FIRST_BAD, '0);
      offer(pis_pkg::ACT_RAISE, SRC_TOP, 8'hff);
      // unused action codes
      offer(ACT_RSVD5, SRC_TOP, 8'hff);
      offer(ACT_RSVD7, '0, '0);
      // level extremes, double enable, locked priority
      offer(pis_pkg::ACT_SETPRIO, '0, 8'hff);
      offer(pis_pkg::ACT_SETPRIO, SRC_LAST, 8'h00);
      offer(pis_pkg::ACT_ENABLE, '0, '0);
      offer(pis_pkg::ACT_ENABLE, '0, '0);
      offer(pis_pkg::ACT_SETPRIO, '0, 8'h01);
      // pending on an enabled and on a disabled source
      offer(pis_pkg::ACT_RAISE, '0, '0);
      offer(pis_pkg::ACT_RAISE, SRC_LAST, '0);
      offer(pis_pkg::ACT_DISPATCH, SRC_TOP, 8'hff);
      offer(pis_pkg::ACT_DISPATCH, '0, '0);
      offer(pis_pkg::ACT_ENABLE, SRC_LAST, '0);
      offer(pis_pkg::ACT_DISPATCH, '0, '0);
      // disable when enabled, then when not
      offer(pis_pkg::ACT_DISABLE, '0, '0);
      offer(pis_pkg::ACT_DISABLE, '0, '0);
      // equal levels keep enable order
      offer(pis_pkg::ACT_SETPRIO, 7'd10, 8'd7);
      offer(pis_pkg::ACT_SETPRIO, 7'd11, 8'd7);
      offer(pis_pkg::ACT_ENABLE, 7'd11, '0);
      offer(pis_pkg::ACT_ENABLE, 7'd10, '0);
      offer(pis_pkg::ACT_RAISE, 7'd10, '0);
      offer(pis_pkg::ACT_RAISE, 7'd11, '0);
      offer(pis_pkg::ACT_DISPATCH, '0, '0);
      offer(pis_pkg::ACT_DISPATCH, '0, '0);

      // random traffic, mostly valid sources, about half from a narrow pool
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400)
            hold_wanted = 1'b1;
         if (n == 900) begin
            // sender waits for every response to drain
            req_valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0)
               @(posedge clock);
         end
         if (n == RANDOM_ITEMS - QUIET_TAIL)
            quiet = 1'b1;

         roll = $urandom_range(0, 99);
         if (roll < 18)
            act = pis_pkg::ACT_SETPRIO;
         else if (roll < 40)
            act = pis_pkg::ACT_ENABLE;
         else if (roll < 52)
            act = pis_pkg::ACT_DISABLE;
         else if (roll < 74)
            act = pis_pkg::ACT_RAISE;
         else if (roll < 96)
            act = pis_pkg::ACT_DISPATCH;
         else
            act = act_code_type'($urandom_range(ACT_RSVD5, ACT_RSVD7));

         roll = $urandom_range(0, 99);
         if (act == pis_pkg::ACT_DISPATCH || roll < 5)
            src = src_num_type'($urandom_range(0, SRC_TOP));
         else if (roll < 55)
            src = src_num_type'($urandom_range(0, 15));
         else
            src = src_num_type'($urandom_range(0, SRC_LAST));

         if ($urandom_range(0, 1) == 0)
            lvl = level_type'($urandom_range(0, 3));
         else
            lvl = level_type'($urandom_range(0, 255));

         offer(act, src, lvl);
      end
      req_valid <= 1'b0;

      // drain, bounded
      spin = 0;
      @(posedge clock);
      while (outstanding != 0 && spin < 5000) begin
         @(posedge clock);
         spin++;
      end
      repeat (10) @(posedge clock);

      if (errors == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
hw/rtl/pis_pkg.sv
hw/rtl/pis_cell.sv
hw/rtl/priority_interrupt_selector_top.sv
bench/pis_checker.sv
bench/tb.sv
